@@ rtl/scp_pkg.sv @@
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants of the text-message command parser
// Parser phases, special byte codes, command codes and the keyword table.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

    // parser phases
    typedef enum logic [1:0] {
        PH_WAIT_QUOTE = 2'd0,
        PH_CAPTURE    = 2'd1,
        PH_WAIT_LF    = 2'd2,
        PH_COLLECT    = 2'd3
    } t_phase;

    // special received bytes
    localparam logic [7:0] BYTE_QUOTE = 8'h22;
    localparam logic [7:0] BYTE_LF    = 8'h0A;

    // command codes
    localparam logic [1:0] CMD_UNKNOWN = 2'd0;
    localparam logic [1:0] CMD_TRACK   = 2'd1;
    localparam logic [1:0] CMD_LOCK    = 2'd2;
    localparam logic [1:0] CMD_UNLOCK  = 2'd3;

    // keyword slots in the match vector
    localparam int WORD_COUNT  = 3;
    localparam int WORD_TRACK  = 0;
    localparam int WORD_LOCK   = 1;
    localparam int WORD_UNLOCK = 2;

    // end of message, parser to output stage
    typedef struct packed {
        logic       fire;
        logic [1:0] code;
    } t_msg_end;

    // keyword length
    function automatic logic [2:0] word_len(input logic [1:0] w);
        logic [2:0] len;
        case (w)
            2'(WORD_TRACK):  len = 3'd5;
            2'(WORD_LOCK):   len = 3'd4;
            2'(WORD_UNLOCK): len = 3'd6;
            default:         len = 3'd0;
        endcase
        return len;
    endfunction

    // keyword character at a position
    function automatic logic [7:0] word_char(input logic [1:0] w, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (w)
            2'(WORD_TRACK): begin
                case (p)
                    3'd0:    c = "t";
                    3'd1:    c = "r";
                    3'd2:    c = "a";
                    3'd3:    c = "c";
                    3'd4:    c = "k";
                    default: c = 8'h00;
                endcase
            end
            2'(WORD_LOCK): begin
                case (p)
                    3'd0:    c = "l";
                    3'd1:    c = "o";
                    3'd2:    c = "c";
                    3'd3:    c = "k";
                    default: c = 8'h00;
                endcase
            end
            2'(WORD_UNLOCK): begin
                case (p)
                    3'd0:    c = "u";
                    3'd1:    c = "n";
                    3'd2:    c = "l";
                    3'd3:    c = "o";
                    3'd4:    c = "c";
                    3'd5:    c = "k";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/scp_parser.sv @@
// ----------------------------------------------------------------------------
// scp_parser: byte-wise parser of the message notice
// Finds the sender field, keeps the tail of the number, collects the message
// line and matches it against the keywords, one byte per cycle while i_beat is high.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_parser #(
    parameter int SENDER_CAPTURE = 13,
    parameter int SENDER_KEEP    = 10,
    parameter int LINE_MAX       = 100
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_beat,
    input  wire logic [7:0]                        i_byte,
    output logic      [SENDER_KEEP-1:0][7:0]       o_store,
    output scp_pkg::t_msg_end                      o_end,
    output logic                                   o_collect
);
    import scp_pkg::*;

    localparam int CW   = $clog2(SENDER_CAPTURE + 1);
    localparam int DROP = (SENDER_CAPTURE > SENDER_KEEP) ? SENDER_CAPTURE - SENDER_KEEP : 0;

    t_phase                          r_phase, n_phase;
    logic [CW-1:0]                   r_count, n_count;
    logic [SENDER_KEEP-1:0][7:0]     r_store, n_store;
    logic [6:0]                      r_len, n_len;
    logic [7:0]                      r_held, n_held;
    logic                            r_held_vld, n_held_vld;
    logic [WORD_COUNT-1:0]           r_alive, n_alive;
    t_msg_end                        msg_end;
    logic [1:0]                      fin_code;

    // command code of the finished line
    always_comb begin
        fin_code = CMD_UNKNOWN;
        if (r_len != 7'd0 && r_len <= 7'(LINE_MAX - 2)) begin
            for (int w = WORD_COUNT - 1; w >= 0; w--) begin
                if (r_alive[w] && r_len == {4'd0, word_len(2'(w))}) begin
                    fin_code = 2'(w + 1);
                end
            end
        end
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_store    = r_store;
        n_len      = r_len;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        n_alive    = r_alive;
        msg_end    = '0;
        if (i_beat) begin
            case (r_phase)
                PH_WAIT_QUOTE: begin
                    if (i_byte == BYTE_QUOTE) begin
                        n_phase = PH_CAPTURE;
                    end
                end
                PH_CAPTURE: begin
                    if (r_count < CW'(SENDER_CAPTURE)) begin
                        for (int k = 0; k < SENDER_KEEP; k++) begin
                            if ((DROP + k) < SENDER_CAPTURE && r_count == CW'(DROP + k)) begin
                                n_store[k] = i_byte;
                            end
                        end
                        n_count = r_count + CW'(1);
                    end else begin
                        n_phase = PH_WAIT_LF;
                    end
                end
                PH_WAIT_LF: begin
                    if (i_byte == BYTE_LF) begin
                        n_phase = PH_COLLECT;
                    end
                end
                PH_COLLECT: begin
                    if (i_byte != BYTE_LF) begin
                        // the held byte is now known not to be the carriage return
                        if (r_held_vld) begin
                            for (int w = 0; w < WORD_COUNT; w++) begin
                                if (!(r_len < {4'd0, word_len(2'(w))} &&
                                      word_char(2'(w), r_len[2:0]) == r_held)) begin
                                    n_alive[w] = 1'b0;
                                end
                            end
                            if (r_len < 7'(LINE_MAX)) begin
                                n_len = r_len + 7'd1;
                            end
                        end
                        n_held     = i_byte;
                        n_held_vld = 1'b1;
                    end else begin
                        msg_end.fire = 1'b1;
                        msg_end.code = fin_code;
                        n_phase      = PH_WAIT_QUOTE;
                        n_count      = '0;
                        n_len        = '0;
                        n_held       = '0;
                        n_held_vld   = 1'b0;
                        n_alive      = '1;
                    end
                end
                default: n_phase = PH_WAIT_QUOTE;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT_QUOTE;
            r_count    <= '0;
            r_len      <= '0;
            r_held     <= '0;
            r_held_vld <= 1'b0;
            r_alive    <= '1;
        end else begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_len      <= n_len;
            r_held     <= n_held;
            r_held_vld <= n_held_vld;
            r_alive    <= n_alive;
        end
    end

    // sender bytes
    always_ff @(posedge i_clk) begin
        r_store <= n_store;
    end

    assign o_store   = r_store;
    assign o_end     = msg_end;
    assign o_collect = (r_phase == PH_COLLECT);

endmodule

`default_nettype wire

@@ rtl/scp_emitter.sv @@
// ----------------------------------------------------------------------------
// scp_emitter: result register and sender number readout
// Takes a copy of the sender number at the end of a message and hands it out
// one byte per output beat, so the parser keeps running meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_emitter #(
    parameter int SENDER_KEEP = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire scp_pkg::t_msg_end                 i_end,
    input  wire logic [SENDER_KEEP-1:0][7:0]       i_store,
    input  wire logic                              i_ready,
    output logic                                   o_valid,
    output logic [7:0]                             o_sender_char,
    output logic [3:0]                             o_char_index,
    output logic [1:0]                             o_command_code,
    output logic                                   o_last
);
    import scp_pkg::*;

    logic                            r_busy, n_busy;
    logic [3:0]                      r_idx, n_idx;
    logic [1:0]                      r_code, n_code;
    logic [SENDER_KEEP-1:0][7:0]     r_snap, n_snap;
    logic                            is_last;

    assign is_last = (r_idx == 4'(SENDER_KEEP - 1));

    // load on message end, shift down on each output beat
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_code = r_code;
        n_snap = r_snap;
        if (i_end.fire) begin
            n_busy = 1'b1;
            n_idx  = 4'd0;
            n_code = i_end.code;
            n_snap = i_store;
        end else if (r_busy && i_ready) begin
            if (is_last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 4'd1;
                for (int k = 0; k < SENDER_KEEP - 1; k++) begin
                    n_snap[k] = r_snap[k + 1];
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 4'd0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_snap <= n_snap;
    end

    assign o_valid        = r_busy;
    assign o_sender_char  = r_snap[0];
    assign o_char_index   = r_idx;
    assign o_command_code = r_code;
    assign o_last         = is_last;

endmodule

`default_nettype wire

@@ rtl/sms_command_parser.sv @@
// ----------------------------------------------------------------------------
// sms_command_parser: command parser for a modem's text-message notice
// Byte-wise parser with a buffered readout of the sender number.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready / i_rx_byte): one received byte per beat.
//   Each byte is parsed in the cycle it is accepted, so a byte per cycle is
//   taken while o_ready is high; the parser state registers hold everything
//   between bytes. Output channel (o_valid / i_ready): SENDER_KEEP beats per
//   message, one sender byte each with its index, the command code and o_last
//   on the final one. The first beat shows in the cycle after the closing line
//   feed is accepted; the rest follow at one per cycle while i_ready is high.
//   The sender number is copied into the output register bank at message end,
//   so the next message is parsed while the previous one drains. Input is
//   held off only in the line-collect phase while the bank is still draining:
//   o_ready is low there until the last beat is taken.
//   When the receiver stalls, the output beat holds unchanged.
//   Reset (synchronous, active low) returns the parser to waiting for a quote
//   and drops any pending output beats; the sender store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_command_parser #(
    parameter int SENDER_CAPTURE = 13,
    parameter int SENDER_KEEP    = 10,
    parameter int LINE_MAX       = 100
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_sender_char,
    output logic [3:0]       o_char_index,
    output logic [1:0]       o_command_code,
    output logic             o_last
);
    import scp_pkg::*;

    logic                            beat;
    logic                            collect;
    logic [SENDER_KEEP-1:0][7:0]     store;
    t_msg_end                        msg_end;

    // bytes of the message line wait while the readout is busy
    assign o_ready = !(o_valid && collect);
    assign beat    = i_valid && o_ready;

    scp_parser #(
        .SENDER_CAPTURE (SENDER_CAPTURE),
        .SENDER_KEEP    (SENDER_KEEP),
        .LINE_MAX       (LINE_MAX)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (beat),
        .i_byte    (i_rx_byte),
        .o_store   (store),
        .o_end     (msg_end),
        .o_collect (collect)
    );

    scp_emitter #(
        .SENDER_KEEP (SENDER_KEEP)
    ) u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_end          (msg_end),
        .i_store        (store),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_sender_char  (o_sender_char),
        .o_char_index   (o_char_index),
        .o_command_code (o_command_code),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

@@ rtl/scp_checker.sv @@
// ----------------------------------------------------------------------------
// scp_checker: port-level checks of the command parser
// Watches the output sequence and the input back-pressure over time.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_checker #(
    parameter int SENDER_KEEP = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_ready,
    input  wire logic        o_valid,
    input  wire logic        i_ready,
    input  wire logic [7:0]  o_sender_char,
    input  wire logic [3:0]  o_char_index,
    input  wire logic [1:0]  o_command_code,
    input  wire logic        o_last
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sender_char) &&
            $stable(o_char_index) && $stable(o_command_code))
        else $error("output beat changed while stalled");

    // beats of one message count up under a fixed code
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid &&
            o_char_index == $past(o_char_index) + 4'd1 && $stable(o_command_code))
        else $error("sender index did not advance");

    // last flag marks the final position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_char_index == 4'(SENDER_KEEP - 1))))
        else $error("last flag on wrong position");

    // a taken last beat is followed by a gap with valid low
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last |=> !o_valid)
        else $error("output valid right after last beat");

    // input back-pressure only while a readout is in progress
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no output pending");

endmodule

bind sms_command_parser scp_checker #(
    .SENDER_KEEP (SENDER_KEEP)
) u_scp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_sender_char  (o_sender_char),
    .o_char_index   (o_char_index),
    .o_command_code (o_command_code),
    .o_last         (o_last)
);

`default_nettype wire

@@ sim/sms_command_parser_checker.sv @@
// ----------------------------------------------------------------------------
// sms_command_parser_checker: result checker for the text-message parser
// Watches both channels of the block. A predictor of its own follows every
// accepted byte and queues the sender beats that a finished message gives.
// Each accepted output beat is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_command_parser_checker #(
    parameter int SENDER_CAPTURE = 13,
    parameter int SENDER_KEEP    = 10,
    parameter int LINE_MAX       = 100
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_sender_char,
    input  wire logic [3:0]  i_char_index,
    input  wire logic [1:0]  i_command_code,
    input  wire logic        i_last,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_beats,
    output int               o_messages,
    output int               o_commands
);

    import scp_pkg::*;

    // leading sender bytes that are captured and thrown away
    localparam int DROP = (SENDER_CAPTURE > SENDER_KEEP) ? SENDER_CAPTURE - SENDER_KEEP : 0;
    localparam int MAX_PRINTS = 40;

    // keywords, right-aligned in 48 bits, first character highest
    localparam logic [47:0] KW_TRACK  = "track";
    localparam logic [47:0] KW_LOCK   = "lock";
    localparam logic [47:0] KW_UNLOCK = "unlock";
    localparam logic [2:0][47:0] KW_TEXT = {KW_UNLOCK, KW_LOCK, KW_TRACK};
    localparam logic [2:0][2:0]  KW_LEN  = {3'd6, 3'd4, 3'd5};
    localparam logic [2:0][1:0]  KW_CODE = {CMD_UNLOCK, CMD_LOCK, CMD_TRACK};

    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] idx;
        logic [1:0] code;
        logic       last;
    } t_sender_beat;

    // predicted parser state
    t_phase       parse_phase;
    int unsigned  capture_cnt;
    logic [7:0]   kept_digits [SENDER_KEEP];
    logic [6:0]   line_len;
    logic [7:0]   held_char;
    logic         held_ok;
    logic [2:0]   kw_alive;

    t_sender_beat sender_beats_q [$];
    int           fail_total = 0;
    int           beat_total = 0;
    int           msg_total = 0;
    int           cmd_total = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_total++;
        if (fail_total <= MAX_PRINTS)
            $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
    endtask

    task automatic clear_message();
        parse_phase = PH_WAIT_QUOTE;
        capture_cnt = 0;
        line_len    = '0;
        held_char   = '0;
        held_ok     = 1'b0;
        kw_alive    = '1;
    endtask

    // one kept line byte narrows the keyword candidates
    task automatic take_line_byte(input logic [7:0] c);
        for (int w = 0; w < WORD_COUNT; w++) begin
            if (line_len >= KW_LEN[w])
                kw_alive[w] = 1'b0;
            else if (KW_TEXT[w][8 * (int'(KW_LEN[w]) - 1 - int'(line_len)) +: 8] != c)
                kw_alive[w] = 1'b0;
        end
        if (line_len < LINE_MAX)
            line_len = line_len + 7'd1;
    endtask

    // closing line feed: queue one beat per kept sender byte
    task automatic close_message();
        logic [1:0]   code;
        t_sender_beat beat;
        code = CMD_UNKNOWN;
        if (line_len != 0 && line_len <= LINE_MAX - 2) begin
            for (int w = 0; w < WORD_COUNT; w++) begin
                if (code == CMD_UNKNOWN && kw_alive[w] && line_len == KW_LEN[w])
                    code = KW_CODE[w];
            end
        end
        for (int k = 0; k < SENDER_KEEP; k++) begin
            beat.ch   = kept_digits[k];
            beat.idx  = 4'(k);
            beat.code = code;
            beat.last = (k == SENDER_KEEP - 1);
            sender_beats_q.push_back(beat);
        end
        clear_message();
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        case (parse_phase)
            PH_WAIT_QUOTE: begin
                if (b == BYTE_QUOTE)
                    parse_phase = PH_CAPTURE;
            end
            PH_CAPTURE: begin
                if (capture_cnt < SENDER_CAPTURE) begin
                    if (capture_cnt >= DROP && capture_cnt - DROP < SENDER_KEEP)
                        kept_digits[capture_cnt - DROP] = b;
                    capture_cnt++;
                end else begin
                    parse_phase = PH_WAIT_LF;
                end
            end
            PH_WAIT_LF: begin
                if (b == BYTE_LF)
                    parse_phase = PH_COLLECT;
            end
            default: begin
                // the newest byte is held back, it may be the carriage return
                if (b != BYTE_LF) begin
                    if (held_ok)
                        take_line_byte(held_char);
                    held_char = b;
                    held_ok   = 1'b1;
                end else begin
                    close_message();
                end
            end
        endcase
    endtask

    // compare output beats first, then advance the predictor on input beats
    always @(posedge i_clk) begin
        t_sender_beat want;
        if (!i_rst_n) begin
            clear_message();
            sender_beats_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (sender_beats_q.size() == 0) begin
                    report_mismatch("beat with nothing expected, char", i_sender_char, 0);
                end else begin
                    want = sender_beats_q.pop_front();
                    if (i_sender_char !== want.ch)
                        report_mismatch("sender_char", i_sender_char, want.ch);
                    if (i_char_index !== want.idx)
                        report_mismatch("char_index", i_char_index, want.idx);
                    if (i_command_code !== want.code)
                        report_mismatch("command_code", i_command_code, want.code);
                    if (i_last !== want.last)
                        report_mismatch("last", i_last, want.last);
                    beat_total++;
                    if (want.last) begin
                        msg_total++;
                        if (want.code != CMD_UNKNOWN)
                            cmd_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                parse_rx_byte(i_rx_byte);
        end
        o_pending    <= sender_beats_q.size();
        o_fail_count <= fail_total;
        o_beats      <= beat_total;
        o_messages   <= msg_total;
        o_commands   <= cmd_total;
    end

endmodule

`default_nettype wire

@@ sim/tb_sms_command_parser.sv @@
// ----------------------------------------------------------------------------
// tb_sms_command_parser: testbench of the text-message command parser
// Sends directed notices (every keyword, empty and overlong lines, missing
// carriage return, zero bytes) and then random notices and broken streams
// under three idling mixes and one long output stall. The checker beside the
// block predicts and compares every sender beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sms_command_parser;

    import scp_pkg::*;

    localparam int LIMIT        = 100000;
    localparam int RANDOM_ITEMS = 180;
    localparam int HOLD_CYCLES  = 400;
    localparam int CAPTURE_LEN  = 13;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  sender_char;
    logic [3:0]  char_index;
    logic [1:0]  cmd_code;
    logic        out_last;

    int          fail_count;
    int          pending;
    int          beats_seen;
    int          msgs_seen;
    int          cmds_seen;

    int          snd_idle = 33;
    int          rcv_idle = 54;
    logic        ready_hold = 1'b0;
    logic        stall_go = 1'b0;
    int          cycle_cnt = 0;
    int          bytes_sent = 0;
    int          planned = 0;
    logic [7:0]  tx_q [$];

    sms_command_parser u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_rx_byte      (rx_byte),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_sender_char  (sender_char),
        .o_char_index   (char_index),
        .o_command_code (cmd_code),
        .o_last         (out_last)
    );

    sms_command_parser_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_rx_byte      (rx_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_sender_char  (sender_char),
        .i_char_index   (char_index),
        .i_command_code (cmd_code),
        .i_last         (out_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_beats        (beats_seen),
        .o_messages     (msgs_seen),
        .o_commands     (cmds_seen)
    );

    // clock
    initial begin
        forever #10 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected", cycle_cnt, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off on request
    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !ready_hold && ($urandom_range(99) >= rcv_idle);
    end

    // long receiver hold-off so the output bank fills and the input stalls
    initial begin : ready_pressure
        wait (stall_go);
        @(posedge clk);
        ready_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        ready_hold <= 1'b0;
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_all();
        while (tx_q.size() > 0)
            send_byte(tx_q.pop_front());
    endtask

    task automatic put(input logic [7:0] b);
        tx_q.push_back(b);
        planned++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    function automatic logic [7:0] rand_not(input logic [7:0] avoid);
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if (c == avoid)
            c = ~c;
        return c;
    endfunction

    // bytes ahead of the quote are ignored and not counted
    task automatic add_noise(input int n);
        repeat (n) tx_q.push_back(rand_not(BYTE_QUOTE));
    endtask

    // quote, sender field, consumed byte, rest of the header, line feed
    task automatic add_header(input int style);
        int junk;
        put(BYTE_QUOTE);
        for (int i = 0; i < CAPTURE_LEN; i++) begin
            case (style)
                0:       put(8'($urandom_range(255)));
                1:       put(i == 0 ? "+" : i == 1 ? "9" : i == 2 ? "1"
                             : 8'("0" + $urandom_range(9)));
                2:       put(8'h00);
                default: put(8'hFF);
            endcase
        end
        put(style == 0 ? 8'($urandom_range(255)) : BYTE_QUOTE);
        junk = (style == 0) ? $urandom_range(4) : 0;
        repeat (junk) put(rand_not(BYTE_LF));
        put(BYTE_LF);
    endtask

    task automatic add_line(input string s, input bit with_cr);
        put_text(s);
        if (with_cr)
            put(BYTE_CR);
        put(BYTE_LF);
    endtask

    task automatic run_directed();
        add_header(1);
        add_line("track", 1'b1);
        add_noise(3);
        add_header(2);
        add_line("lock", 1'b1);
        add_header(3);
        add_line("unlock", 1'b1);
        // empty line right after the opening line feed
        add_header(0);
        put(BYTE_LF);
        // carriage return only
        add_header(0);
        add_line("", 1'b1);
        // no carriage return, so the last letter is dropped
        add_header(1);
        add_line("track", 1'b0);
        add_header(0);
        add_line("tracks", 1'b1);
        add_header(0);
        add_line("loc", 1'b1);
        // zero byte inside the line
        add_header(1);
        put_text("lo");
        put(8'h00);
        put_text("ck");
        put(BYTE_CR);
        put(BYTE_LF);
        // line past the buffer limit, so the length saturates
        add_header(3);
        repeat (105) put(rand_not(BYTE_LF));
        add_line("", 1'b1);
        send_all();
    endtask

    // mostly well-formed notices with random content, some broken streams
    task automatic random_message();
        int         kind;
        int         w;
        int         n;
        string      s;
        logic [7:0] c;
        if ($urandom_range(3) == 0)
            add_noise($urandom_range(1, 3));
        add_header(($urandom_range(99) < 70) ? 0 : $urandom_range(1, 3));
        w = $urandom_range(WORD_COUNT - 1);
        s = (w == WORD_TRACK) ? "track" : (w == WORD_LOCK) ? "lock" : "unlock";
        kind = $urandom_range(99);
        if (kind < 55) begin
            add_line(s, 1'b1);
        end else if (kind < 65) begin
            if ($urandom_range(1)) begin
                add_line(s, 1'b0);
            end else begin
                put_text(s);
                put(rand_not(BYTE_LF));
                add_line("", 1'b1);
            end
        end else if (kind < 78) begin
            // one letter replaced
            n = $urandom_range(s.len() - 1);
            c = rand_not(BYTE_LF);
            for (int i = 0; i < s.len(); i++)
                put((i == n) ? c : s[i]);
            add_line("", 1'b1);
        end else if (kind < 90) begin
            repeat ($urandom_range(8)) put(rand_not(BYTE_LF));
            add_line("", 1'($urandom_range(1)));
        end else if (kind < 97) begin
            // broken stream: raw bytes of any value
            repeat ($urandom_range(3, 25)) put(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(97, 120)) put(rand_not(BYTE_LF));
            add_line("", 1'b1);
        end
        send_all();
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = planned + count;
        while (planned < stop_at)
            random_message();
    endtask

    // stimulus and verdict
    initial begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(RANDOM_ITEMS / 3);

        snd_idle = 54;
        rcv_idle <= 33;
        run_random(RANDOM_ITEMS / 3);

        snd_idle = 0;
        rcv_idle <= 0;
        stall_go <= 1'b1;
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d bytes over three idling mixes and a %0d-cycle output hold-off",
                 bytes_sent, HOLD_CYCLES);
        $display("checked %0d sender beats from %0d notices, %0d of them known commands",
                 beats_seen, msgs_seen, cmds_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
